// File: src/kuz_pkg.sv
// Package: Kuznyechik S-box, linear transform helpers and shared types.
`default_nettype none
package kuz_pkg;

   localparam int RK_COUNT       = 10;
   localparam int RK_IDX_W       = $clog2(RK_COUNT);
   localparam int KEY_WORD_COUNT = 4;
   localparam int CSR_IDX_W      = 8;
   localparam int EXP_ROUNDS     = 32;
   localparam int LIN_STEPS      = 16;
   localparam int STEPS_PER_CYC  = 4;
   localparam int LIN_CYCLES     = LIN_STEPS / STEPS_PER_CYC;
   localparam logic [7:0] GF_POLY = 8'hC3;

   typedef enum logic [1:0] {
      UNIT_SUB = 2'b01,
      UNIT_LIN = 2'b10
   } unit_op_type;

   typedef struct packed {
      unit_op_type op;
   } unit_ctrl_type;

   localparam logic [7:0] LIN_COEF [0:15] = '{
      8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
      8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
   };

   localparam logic [7:0] SBOX [0:255] = '{
      8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
      8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
      8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
      8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
      8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
      8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
      8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
      8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
      8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
      8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
      8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
      8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
      8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
      8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
      8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
      8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
   };

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] x;
      logic [7:0] p;
      x = a;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            p = p ^ x;
         end
         x = x[7] ? ((x << 1) ^ GF_POLY) : (x << 1);
      end
      return p;
   endfunction

   function automatic logic [127:0] r_step(input logic [127:0] x);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 16; i++) begin
         acc = acc ^ gf_mul(x[127 - 8*i -: 8], LIN_COEF[i]);
      end
      return {acc, x[127:8]};
   endfunction

   function automatic logic [127:0] lin_part(input logic [127:0] x);
      logic [127:0] y;
      y = x;
      for (int s = 0; s < STEPS_PER_CYC; s++) begin
         y = r_step(y);
      end
      return y;
   endfunction

   function automatic logic [127:0] sub_layer(input logic [127:0] x);
      logic [127:0] y;
      y = '0;
      for (int i = 0; i < 16; i++) begin
         y[8*i +: 8] = SBOX[x[8*i +: 8]];
      end
      return y;
   endfunction

endpackage
`default_nettype wire

// File: src/kuz_round_unit.sv
// Shared round unit: keyed S-box layer or a quarter of the linear transform.
`default_nettype none
module kuz_round_unit
   import kuz_pkg::*;
(
   input  wire unit_ctrl_type ctrl,
   input  wire logic [127:0]  data_in,
   input  wire logic [127:0]  key_in,
   output logic [127:0]       data_out
);

   always_comb begin
      unique case (ctrl.op)
         UNIT_SUB: data_out = sub_layer(data_in ^ key_in);
         UNIT_LIN: data_out = lin_part(data_in);
         default:  data_out = data_in;
      endcase
   end

endmodule
`default_nettype wire

// File: src/gost_128bit_block_encrypt_core.sv
// Top level: Kuznyechik encryption core with key expansion sequencer.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------------
//   request | start, busy, req_plain_hi/lo            | beat when start && !busy
//   result  | rsp_valid, rsp_cipher_hi/lo             | one-cycle strobe, no stall
//   csr     | csr_we, csr_index, csr_wdata            | key write when csr_we && csr_index < 4
//
// One round runs through the shared round unit as an S layer, then 4 linear quarters.
// A block runs 9 such rounds, then a final step that adds the last round key and registers the result beat.
// After reset or any key write (csr_index below 4), the first block first runs 32 rounds of key expansion.
// Reset clears the key registers and marks the round keys stale.
// The result strobe cannot be stalled.
`default_nettype none
module gost_128bit_block_encrypt_core
   import kuz_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [63:0]          req_plain_hi,
   input  wire logic [63:0]          req_plain_lo,
   output logic                      rsp_valid,
   output logic [63:0]               rsp_cipher_hi,
   output logic [63:0]               rsp_cipher_lo,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]          csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CONST_L = 6'b000010,
      ST_EXP_S   = 6'b000100,
      ST_EXP_L   = 6'b001000,
      ST_ENC_S   = 6'b010000,
      ST_ENC_L   = 6'b100000
   } state_type;

   localparam logic [RK_IDX_W-1:0] RK_LAST = RK_IDX_W'(RK_COUNT - 1);
   localparam logic [1:0]          SUB_LAST = 2'(LIN_CYCLES - 1);
   localparam logic [4:0]          KR_LAST = 5'(EXP_ROUNDS - 1);

   state_type state_ff, state_in;
   logic [1:0]            sub_ff, sub_in;
   logic [4:0]            kr_ff, kr_in;
   logic [RK_IDX_W-1:0]   rnd_ff, rnd_in;
   logic                  expanded_ff, expanded_in;
   logic                  valid_ff, valid_in;
   logic [63:0]           key_ff [KEY_WORD_COUNT];
   logic [127:0]          rk_ff [RK_COUNT];
   logic [127:0]          st_ff, st_in;
   logic [127:0]          a1_ff, a1_in;
   logic [127:0]          a0_ff, a0_in;
   logic [127:0]          blk_ff, blk_in;
   logic [127:0]          out_ff, out_in;
   logic                  rk_we;
   logic [RK_IDX_W-1:0]   rk_wa;
   logic [127:0]          rk_wd0, rk_wd1;
   logic                  rk_init;
   unit_ctrl_type         uctrl;
   logic [127:0]          ukey;
   logic [127:0]          uout;

   kuz_round_unit u_unit (
      .ctrl     (uctrl),
      .data_in  (st_ff),
      .key_in   (ukey),
      .data_out (uout)
   );

   always_comb begin
      state_in    = state_ff;
      sub_in      = sub_ff;
      kr_in       = kr_ff;
      rnd_in      = rnd_ff;
      expanded_in = expanded_ff;
      valid_in    = 1'b0;
      st_in       = st_ff;
      a1_in       = a1_ff;
      a0_in       = a0_ff;
      blk_in      = blk_ff;
      out_in      = out_ff;
      rk_we       = 1'b0;
      rk_init     = 1'b0;
      rk_wa       = RK_IDX_W'({kr_ff[4:3], 1'b0}) + RK_IDX_W'(2);
      rk_wd0      = uout ^ a0_ff;
      rk_wd1      = a1_ff;
      uctrl.op    = UNIT_LIN;
      ukey        = rk_ff[rnd_ff];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               blk_in = {req_plain_hi, req_plain_lo};
               rnd_in = '0;
               sub_in = '0;
               if (expanded_ff) begin
                  st_in    = {req_plain_hi, req_plain_lo};
                  state_in = ST_ENC_S;
               end else begin
                  a1_in    = {key_ff[3], key_ff[2]};
                  a0_in    = {key_ff[1], key_ff[0]};
                  rk_init  = 1'b1;
                  kr_in    = '0;
                  st_in    = {120'd0, 8'd1};
                  state_in = ST_CONST_L;
               end
            end
         end
         ST_CONST_L: begin
            st_in  = uout;
            sub_in = sub_ff + 2'd1;
            if (sub_ff == SUB_LAST) begin
               state_in = ST_EXP_S;
            end
         end
         ST_EXP_S: begin
            uctrl.op = UNIT_SUB;
            ukey     = a1_ff;
            st_in    = uout;
            sub_in   = '0;
            state_in = ST_EXP_L;
         end
         ST_EXP_L: begin
            st_in  = uout;
            sub_in = sub_ff + 2'd1;
            if (sub_ff == SUB_LAST) begin
               a1_in = uout ^ a0_ff;
               a0_in = a1_ff;
               rk_we = (kr_ff[2:0] == 3'd7);
               if (kr_ff == KR_LAST) begin
                  expanded_in = 1'b1;
                  st_in       = blk_ff;
                  rnd_in      = '0;
                  state_in    = ST_ENC_S;
               end else begin
                  kr_in    = kr_ff + 5'd1;
                  st_in    = {120'd0, 8'({3'd0, kr_ff}) + 8'd2};
                  state_in = ST_CONST_L;
               end
            end
         end
         ST_ENC_S: begin
            uctrl.op = UNIT_SUB;
            if (rnd_ff == RK_LAST) begin
               out_in   = st_ff ^ rk_ff[rnd_ff];
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               st_in    = uout;
               sub_in   = '0;
               state_in = ST_ENC_L;
            end
         end
         ST_ENC_L: begin
            st_in  = uout;
            sub_in = sub_ff + 2'd1;
            if (sub_ff == SUB_LAST) begin
               rnd_in   = rnd_ff + RK_IDX_W'(1);
               state_in = ST_ENC_S;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we && (csr_index < CSR_IDX_W'(KEY_WORD_COUNT))) begin
         expanded_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sub_ff      <= '0;
         kr_ff       <= '0;
         rnd_ff      <= '0;
         expanded_ff <= 1'b0;
         valid_ff    <= 1'b0;
         for (int i = 0; i < KEY_WORD_COUNT; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         sub_ff      <= sub_in;
         kr_ff       <= kr_in;
         rnd_ff      <= rnd_in;
         expanded_ff <= expanded_in;
         valid_ff    <= valid_in;
         if (csr_we && (csr_index < CSR_IDX_W'(KEY_WORD_COUNT))) begin
            key_ff[csr_index[1:0]] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff  <= st_in;
      a1_ff  <= a1_in;
      a0_ff  <= a0_in;
      blk_ff <= blk_in;
      out_ff <= out_in;
      if (rk_init) begin
         rk_ff[0] <= {key_ff[3], key_ff[2]};
         rk_ff[1] <= {key_ff[1], key_ff[0]};
      end
      if (rk_we) begin
         rk_ff[rk_wa]                 <= rk_wd0;
         rk_ff[rk_wa + RK_IDX_W'(1)]  <= rk_wd1;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_cipher_hi = out_ff[127:64];
   assign rsp_cipher_lo = out_ff[63:0];

`ifndef SYNTHESIS
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat not started");
   a_beat_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(state_ff == ST_ENC_S))) else $error("stray result");
   a_enc_keys: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ENC_L) |-> (expanded_ff && rnd_ff < RK_LAST))
      else $error("encrypt without keys");
`endif

endmodule
`default_nettype wire

// File: verif/gost_128bit_block_encrypt_core_test.sv
// Testbench: block encryption and key expansion checked against a built-in cipher model.
`default_nettype none
module gost_128bit_block_encrypt_core_test
   import kuz_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_CYCLES = 400;
   localparam int NUM_KEY_REGS = 4;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } block_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [63:0]          req_plain_hi = '0;
   logic [63:0]          req_plain_lo = '0;
   logic                 rsp_valid;
   logic [63:0]          rsp_cipher_hi;
   logic [63:0]          rsp_cipher_lo;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_wdata = '0;

   logic [63:0]  key_reg [NUM_KEY_REGS];
   logic [127:0] round_key [RK_COUNT];
   logic         keys_fresh;
   block_type    cipher_expect [$];
   int           fail_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;

   gost_128bit_block_encrypt_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_plain_hi(req_plain_hi), .req_plain_lo(req_plain_lo),
      .rsp_valid(rsp_valid), .rsp_cipher_hi(rsp_cipher_hi), .rsp_cipher_lo(rsp_cipher_lo),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] sh;
      acc = '0;
      sh = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc ^= sh;
         end
         sh = sh[7] ? ((sh << 1) ^ 8'hC3) : (sh << 1);
      end
      return acc;
   endfunction

   function automatic logic [127:0] mix_bytes(input logic [127:0] x);
      logic [7:0] acc;
      for (int r = 0; r < 16; r++) begin
         acc = '0;
         for (int i = 0; i < 16; i++) begin
            acc ^= field_mul(x[127 - 8*i -: 8], LIN_COEF[i]);
         end
         x = {acc, x[127:8]};
      end
      return x;
   endfunction

   function automatic logic [127:0] subst_mix(input logic [127:0] x);
      for (int i = 0; i < 16; i++) begin
         x[8*i +: 8] = SBOX[x[8*i +: 8]];
      end
      return mix_bytes(x);
   endfunction

   task automatic expand_round_keys();
      logic [127:0] a1, a0, t;
      a1 = {key_reg[3], key_reg[2]};
      a0 = {key_reg[1], key_reg[0]};
      round_key[0] = a1;
      round_key[1] = a0;
      for (int n = 0; n < 32; n++) begin
         t = subst_mix(a1 ^ mix_bytes(128'(n + 1))) ^ a0;
         a0 = a1;
         a1 = t;
         if (n % 8 == 7) begin
            round_key[n/4 + 1] = a1;
            round_key[n/4 + 2] = a0;
         end
      end
      keys_fresh = 1'b1;
   endtask

   task automatic encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
      logic [127:0] b;
      if (!keys_fresh) begin
         expand_round_keys();
      end
      b = {hi, lo};
      for (int r = 0; r < RK_COUNT - 1; r++) begin
         b = subst_mix(b ^ round_key[r]);
      end
      b ^= round_key[RK_COUNT-1];
      cipher_expect.push_back('{hi: b[127:64], lo: b[63:0]});
   endtask

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
      start <= 1'b1;
      req_plain_hi <= hi;
      req_plain_lo <= lo;
      do @(posedge clock); while (busy);
      encrypt_block(hi, lo);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      start <= 1'b0;
      while (cipher_expect.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx < NUM_KEY_REGS) begin
         key_reg[idx] = value;
         keys_fresh = 1'b0;
      end
   endtask

   task automatic load_key(input logic [255:0] k);
      for (int i = 0; i < NUM_KEY_REGS; i++) begin
         write_csr(CSR_IDX_W'(i), k[64*i +: 64]);
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   always @(posedge clock) begin
      block_type exp_blk;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (cipher_expect.size() == 0) begin
            $error("unexpected result beat cipher_hi=%h cipher_lo=%h",
                   rsp_cipher_hi, rsp_cipher_lo);
            fail_count++;
         end else begin
            exp_blk = cipher_expect.pop_front();
            if (rsp_cipher_hi !== exp_blk.hi) begin
               $error("cipher_hi expected %h actual %h", exp_blk.hi, rsp_cipher_hi);
               fail_count++;
            end
            if (rsp_cipher_lo !== exp_blk.lo) begin
               $error("cipher_lo expected %h actual %h", exp_blk.lo, rsp_cipher_lo);
               fail_count++;
            end
         end
      end
   end

   task automatic test_reset_key();
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h8000_0000_0000_0000, 64'h1);
   endtask

   task automatic test_standard_vector();
      load_key(256'h8899aabbccddeeff0011223344556677fedcba98765432100123456789abcdef);
      send_block(64'h1122334455667700, 64'hffeeddccbbaa9988);
      send_block('0, '1);
      send_block('1, '0);
   endtask

   task automatic test_key_extremes();
      load_key('1);
      send_block('0, '0);
      send_block('1, '1);
      load_key('0);
      send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      write_csr(CSR_IDX_W'(2), 64'h1);
      send_block('0, '0);
   endtask

   task automatic test_ignored_index();
      write_csr('1, '1);
      write_csr(CSR_IDX_W'(NUM_KEY_REGS), 64'hDEAD_BEEF_0123_4567);
      write_csr(CSR_IDX_W'($urandom_range(NUM_KEY_REGS, 254)), rand64());
      send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
      send_block('0, '0);
   endtask

   task automatic test_random(input int pct, input int n_blocks);
      send_idle_pct = pct;
      for (int k = 0; k < 3; k++) begin
         if ($urandom_range(3) == 0) begin
            write_csr(CSR_IDX_W'($urandom_range(3)), rand64());
         end else begin
            load_key({rand64(), rand64(), rand64(), rand64()});
         end
         if ($urandom_range(4) == 0) begin
            write_csr(CSR_IDX_W'($urandom_range(NUM_KEY_REGS, 255)), rand64());
         end
         for (int i = 0; i < n_blocks; i++) begin
            send_block(rand64(), rand64());
         end
      end
      send_idle_pct = 0;
   endtask

   initial begin
      for (int i = 0; i < NUM_KEY_REGS; i++) begin
         key_reg[i] = '0;
      end
      keys_fresh = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_key();
      test_standard_vector();
      test_key_extremes();
      test_ignored_index();
      test_random(0, 125);
      test_random(52, 125);
      test_random(22, 125);
      test_random(0, 125);
      start <= 1'b0;
      while (cipher_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire
